@@ rtl/aws_pkg.sv @@
// ----------------------------------------------------------------------------
// aws_pkg
// Shared types and constants for the box table and collision step block.
// ----------------------------------------------------------------------------
package aws_pkg;

  localparam int unsigned MAX_BODIES_DEF = 16;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_VEL  = 2'd1,
    KIND_STEP = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BADIX = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MV_RD,
    S_MV_MULX,
    S_MV_MULY,
    S_MV_WR,
    S_PR_RDA,
    S_PR_RDB,
    S_PR_EVAL,
    S_PR_WR,
    S_OUT_RD,
    S_OUT_SEND,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         body_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        box_width;
    logic [30:0]        box_height;
    logic               fixed_flag;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [23:0]        step_dt;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last;
  } out_item_t;

  // Clamp a 34-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ rtl/aabb_world_step.sv @@
// ----------------------------------------------------------------------------
// aabb_world_step
// Box table with motion and pairwise push-apart collision, one shared
// multiplier and one shared edge comparator under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready   | in_item_t
//  out_    | output    | out_valid/out_ready | out_item_t
//
// Add and velocity items go from accept to the response state and wait there
// for the output. A step item moves each box (read, multiply x, multiply y,
// write), then takes each of the N*(N-1)/2 pairs (read a, read b, evaluate,
// write, with a second write when the pair overlaps) and reports each box
// (read, send), with N the box count, all through the single-port table.
// Reset clears the box count and sequencer only; table entries are not
// cleared. A stalled out_ready holds the sequencer at the current result.
module aabb_world_step
  import aws_pkg::*;
#(
  parameter int unsigned MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned IW = $clog2(MAX_BODIES);
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);

  // Box table memories
  logic signed [31:0] mem_x [MAX_BODIES];
  logic signed [31:0] mem_y [MAX_BODIES];
  logic [30:0]        mem_w [MAX_BODIES];
  logic [30:0]        mem_h [MAX_BODIES];
  logic signed [31:0] mem_vx [MAX_BODIES];
  logic signed [31:0] mem_vy [MAX_BODIES];
  logic               mem_f [MAX_BODIES];

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  // Read data registers (box a and box b)
  logic signed [31:0] ax_r, ay_r, bx_r, by_r, avx_r, avy_r;
  logic [30:0] aw_r, ah_r, bw_r, bh_r;
  logic af_r, bf_r;
  logic [IW-1:0] rd_addr;
  logic rd_to_b;
  logic rd_en;

  // Shared multiplier result register
  logic signed [56:0] prod_r;
  logic signed [31:0] mx_r;

  // Pair evaluation results
  logic signed [31:0] nax_r, nay_r, nbx_r, nby_r;
  logic hit_r;
  logic hit_b_r;

  // Write controls
  logic wr_pos_a, wr_pos_b, wr_add, wr_vel;

  logic [CW-1:0] i_ext, j_ext;
  assign i_ext = CW'(i_r);
  assign j_ext = CW'(j_r);

  // Shared multiplier: velocity times step_dt, registered
  logic signed [31:0] mul_a;
  logic signed [56:0] mul_p;
  logic signed [56:0] rnd;
  logic signed [41:0] stp_w;
  logic signed [33:0] step_v;
  logic signed [31:0] mv_y;
  assign mul_a = (state_r == S_MV_MULX) ? avx_r : avy_r;
  assign mul_p = 57'(mul_a) * $signed({1'b0, item_r.step_dt});
  assign rnd   = prod_r + 57'sd32768;
  // Arithmetic shift floors, matching add-half-then-floor
  assign stp_w = 42'(rnd >>> 16);

  // Bound the step; anything past one full range saturates the same way
  always_comb begin
    if (stp_w > 42'sh1_0000_0000) begin
      step_v = 34'sh1_0000_0000;
    end else if (stp_w < -42'sh1_0000_0000) begin
      step_v = -34'sh1_0000_0000;
    end else begin
      step_v = stp_w[33:0];
    end
  end
  assign mv_y = sat32(34'(ay_r) + step_v);

  // Shared edge comparator unit
  logic signed [32:0] ax2, bx2, ay2, by2, ovx, ovy, ovs;
  logic hit_c, horiz;
  logic signed [33:0] pa, pb;
  logic a_first;
  logic signed [31:0] nax_c, nay_c, nbx_c, nby_c;
  always_comb begin
    ax2 = 33'(ax_r) + 33'($signed({1'b0, aw_r}));
    bx2 = 33'(bx_r) + 33'($signed({1'b0, bw_r}));
    ay2 = 33'(ay_r) + 33'($signed({1'b0, ah_r}));
    by2 = 33'(by_r) + 33'($signed({1'b0, bh_r}));
    hit_c = !(ax2 < 33'(bx_r) || 33'(ax_r) > bx2) &&
            !(ay2 < 33'(by_r) || 33'(ay_r) > by2) && !(af_r && bf_r);
    ovx = ((ax2 < bx2) ? ax2 : bx2) - ((ax_r > bx_r) ? 33'(ax_r) : 33'(bx_r));
    ovy = ((ay2 < by2) ? ay2 : by2) - ((ay_r > by_r) ? 33'(ay_r) : 33'(by_r));
    horiz = ovx < ovy;
    ovs = horiz ? ovx : ovy;
    pa = horiz ? 34'(ax_r) : 34'(ay_r);
    pb = horiz ? 34'(bx_r) : 34'(by_r);
    a_first = pa < pb;
    nax_c = ax_r;
    nay_c = ay_r;
    nbx_c = bx_r;
    nby_c = by_r;
    if (horiz) begin
      if (!af_r) nax_c = sat32(a_first ? pa - 34'(ovs) : pa + 34'(ovs));
      if (!bf_r) nbx_c = sat32(a_first ? pb + 34'(ovs) : pb - 34'(ovs));
    end else begin
      if (!af_r) nay_c = sat32(a_first ? pa - 34'(ovs) : pa + 34'(ovs));
      if (!bf_r) nby_c = sat32(a_first ? pb + 34'(ovs) : pb - 34'(ovs));
    end
  end

  // Synchronous table read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_to_b) begin
        bx_r <= mem_x[rd_addr];
        by_r <= mem_y[rd_addr];
        bw_r <= mem_w[rd_addr];
        bh_r <= mem_h[rd_addr];
        bf_r <= mem_f[rd_addr];
      end else begin
        ax_r  <= mem_x[rd_addr];
        ay_r  <= mem_y[rd_addr];
        aw_r  <= mem_w[rd_addr];
        ah_r  <= mem_h[rd_addr];
        af_r  <= mem_f[rd_addr];
        avx_r <= mem_vx[rd_addr];
        avy_r <= mem_vy[rd_addr];
      end
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (wr_add) begin
      mem_x[count_r[IW-1:0]]  <= item_r.pos_x;
      mem_y[count_r[IW-1:0]]  <= item_r.pos_y;
      mem_w[count_r[IW-1:0]]  <= item_r.box_width;
      mem_h[count_r[IW-1:0]]  <= item_r.box_height;
      mem_f[count_r[IW-1:0]]  <= item_r.fixed_flag;
      mem_vx[count_r[IW-1:0]] <= '0;
      mem_vy[count_r[IW-1:0]] <= '0;
    end else if (wr_vel) begin
      mem_vx[IW'(item_r.body_index)] <= item_r.vel_x;
      mem_vy[IW'(item_r.body_index)] <= item_r.vel_y;
    end else if (wr_pos_a) begin
      if (state_r == S_MV_WR) begin
        mem_x[i_r]  <= mx_r;
        mem_y[i_r]  <= mv_y;
        mem_vx[i_r] <= '0;
        mem_vy[i_r] <= '0;
      end else begin
        mem_x[i_r] <= nax_r;
        mem_y[i_r] <= nay_r;
      end
    end else if (wr_pos_b) begin
      mem_x[j_r] <= nbx_r;
      mem_y[j_r] <= nby_r;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    if (state_r == S_MV_MULX || state_r == S_MV_MULY) begin
      prod_r <= mul_p;
    end
    if (state_r == S_MV_MULY) begin
      mx_r <= sat32(34'(ax_r) + step_v);
    end
    if (state_r == S_PR_EVAL) begin
      hit_r <= hit_c;
      nax_r <= nax_c;
      nay_r <= nay_c;
      nbx_r <= nbx_c;
      nby_r <= nby_c;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.kind)
            KIND_ADD, KIND_VEL: state_nxt = S_RESP;
            KIND_STEP: state_nxt = (count_r == '0) ? S_RESP : S_MV_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MV_RD:   state_nxt = S_MV_MULX;
      S_MV_MULX: state_nxt = S_MV_MULY;
      S_MV_MULY: state_nxt = S_MV_WR;
      S_MV_WR: begin
        if (i_ext + 1'b1 < count_r) state_nxt = S_MV_RD;
        else if (count_r > 1) state_nxt = S_PR_RDA;
        else state_nxt = S_OUT_RD;
      end
      S_PR_RDA:  state_nxt = S_PR_RDB;
      S_PR_RDB:  state_nxt = S_PR_EVAL;
      S_PR_EVAL: state_nxt = S_PR_WR;
      S_PR_WR: begin
        if (!hit_r || hit_b_r) begin
          // pair done (b written or no hit)
          if (j_ext + 1'b1 < count_r) state_nxt = S_PR_RDA;
          else if (i_ext + 2 < count_r) state_nxt = S_PR_RDA;
          else state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD:   state_nxt = S_OUT_SEND;
      S_OUT_SEND: begin
        if (out_valid_r && out_ready) begin
          state_nxt = (i_ext + 1'b1 < count_r) ? S_OUT_RD : S_IDLE;
        end
      end
      S_RESP: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_ff @(posedge clk) begin
    if (!rst_n) hit_b_r <= 1'b0;
    else if (state_r == S_PR_EVAL) hit_b_r <= 1'b0;
    else if (state_r == S_PR_WR && hit_r) hit_b_r <= ~hit_b_r;
  end

  always_comb begin
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    rd_to_b       = 1'b0;
    rd_addr       = i_r;
    wr_add        = 1'b0;
    wr_vel        = 1'b0;
    wr_pos_a      = 1'b0;
    wr_pos_b      = 1'b0;
    in_ready      = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        item_nxt = in_data;
        i_nxt    = '0;
        j_nxt    = IW'(1);
        res_nxt  = '0;
        res_nxt.last = 1'b1;
        if (in_valid) begin
          unique case (in_data.kind)
            KIND_ADD: begin
              if (count_r == CW'(MAX_BODIES)) begin
                res_nxt.status = ST_FULL;
              end else begin
                res_nxt.status    = ST_OK;
                res_nxt.out_index = 4'(count_r);
                res_nxt.out_x     = in_data.pos_x;
                res_nxt.out_y     = in_data.pos_y;
              end
              out_valid_nxt = 1'b1;
            end
            KIND_VEL: begin
              res_nxt.out_index = in_data.body_index;
              res_nxt.status = (32'(in_data.body_index) >= 32'(count_r))
                               ? ST_BADIX : ST_OK;
              out_valid_nxt = 1'b1;
            end
            KIND_STEP: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                out_valid_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_MV_RD: rd_en = 1'b1;
      S_MV_MULX, S_MV_MULY: ;
      S_MV_WR: begin
        wr_pos_a = !af_r;
        if (i_ext + 1'b1 < count_r) begin
          i_nxt = i_r + 1'b1;
        end else begin
          i_nxt = '0;
          j_nxt = IW'(1);
        end
      end
      S_PR_RDA: rd_en = 1'b1;
      S_PR_RDB: begin
        rd_en = 1'b1;
        rd_to_b = 1'b1;
        rd_addr = j_r;
      end
      S_PR_EVAL: ;
      S_PR_WR: begin
        if (hit_r && !hit_b_r) begin
          wr_pos_a = 1'b1;
        end else begin
          wr_pos_b = hit_r;
          if (j_ext + 1'b1 < count_r) begin
            j_nxt = j_r + 1'b1;
          end else if (i_ext + 2 < count_r) begin
            i_nxt = i_r + 1'b1;
            j_nxt = i_r + IW'(2);
          end else begin
            i_nxt = '0;
          end
        end
      end
      S_OUT_RD: rd_en = 1'b1;
      S_OUT_SEND: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          res_nxt.status    = ST_OK;
          res_nxt.out_index = 4'(i_r);
          res_nxt.out_x     = ax_r;
          res_nxt.out_y     = ay_r;
          res_nxt.last      = (i_ext + 1'b1 == count_r);
        end else if (out_ready) begin
          out_valid_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
        end
      end
      S_RESP: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (item_r.kind == KIND_ADD && count_r != CW'(MAX_BODIES)) begin
            wr_add = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (item_r.kind == KIND_VEL && res_r.status == ST_OK) wr_vel = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

@@ rtl/aws_checker.sv @@
// ----------------------------------------------------------------------------
// aws_checker
// Port-level checks for the box table block.
// ----------------------------------------------------------------------------
module aws_checker
  import aws_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Never take an item while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted with result pending");

  // Error results are single and final
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("error result not last");

  // Full and empty results carry zero position
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL || out_data.status == ST_EMPTY)
      |-> out_data.out_x == 0 && out_data.out_y == 0)
    else $error("error result with nonzero position");

endmodule

bind aabb_world_step aws_checker u_aws_checker (.*);

@@ sim/aws_checker.sv @@
// ----------------------------------------------------------------------------
// aws_scoreboard
// Watches both channels of the box table block, keeps its own copy of the
// box table, predicts every result of each accepted item and compares the
// returned results field by field in order.
// ----------------------------------------------------------------------------
module aws_scoreboard
  import aws_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        step_count,
  output int        result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = MAX_BODIES_DEF;

  logic signed [63:0] tbl_x [NB];
  logic signed [63:0] tbl_y [NB];
  logic signed [63:0] tbl_w [NB];
  logic signed [63:0] tbl_h [NB];
  logic signed [63:0] spd_x [NB];
  logic signed [63:0] spd_y [NB];
  logic               tbl_fix [NB];
  int                 n_boxes;
  out_item_t          expected_results [$];

  assign pending = expected_results.size();

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // Velocity times Q8.16 time, rounded half up to Q24.8
  function automatic logic signed [63:0] motion(logic signed [63:0] vel,
                                                logic signed [63:0] dt);
    logic signed [63:0] p;
    p = vel * dt + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] min2(logic signed [63:0] a,
                                              logic signed [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [63:0] max2(logic signed [63:0] a,
                                              logic signed [63:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic out_item_t mk(status_t st, int idx, logic signed [63:0] x,
                                   logic signed [63:0] y, logic lst);
    out_item_t r;
    r.status    = st;
    r.out_index = idx[3:0];
    r.out_x     = x[31:0];
    r.out_y     = y[31:0];
    r.last      = lst;
    return r;
  endfunction

  // Push one overlapping pair apart along the axis of smaller overlap
  task automatic separate_pair(int a, int b);
    logic signed [63:0] ax2, bx2, ay2, by2, ovx, ovy;
    logic               fa, fb;
    ax2 = tbl_x[a] + tbl_w[a];
    bx2 = tbl_x[b] + tbl_w[b];
    ay2 = tbl_y[a] + tbl_h[a];
    by2 = tbl_y[b] + tbl_h[b];
    fa  = tbl_fix[a];
    fb  = tbl_fix[b];
    if (ax2 < tbl_x[b] || tbl_x[a] > bx2) return;
    if (ay2 < tbl_y[b] || tbl_y[a] > by2) return;
    if (fa && fb) return;
    ovx = min2(ax2, bx2) - max2(tbl_x[a], tbl_x[b]);
    ovy = min2(ay2, by2) - max2(tbl_y[a], tbl_y[b]);
    if (ovx < ovy) begin
      if (tbl_x[a] < tbl_x[b]) begin
        if (!fa) tbl_x[a] = clamp32(tbl_x[a] - ovx);
        if (!fb) tbl_x[b] = clamp32(tbl_x[b] + ovx);
      end else begin
        if (!fa) tbl_x[a] = clamp32(tbl_x[a] + ovx);
        if (!fb) tbl_x[b] = clamp32(tbl_x[b] - ovx);
      end
    end else begin
      if (tbl_y[a] < tbl_y[b]) begin
        if (!fa) tbl_y[a] = clamp32(tbl_y[a] - ovy);
        if (!fb) tbl_y[b] = clamp32(tbl_y[b] + ovy);
      end else begin
        if (!fa) tbl_y[a] = clamp32(tbl_y[a] + ovy);
        if (!fb) tbl_y[b] = clamp32(tbl_y[b] - ovy);
      end
    end
  endtask

  // Update the table copy and queue the results of one item
  task automatic predict_world(in_item_t it);
    logic signed [63:0] dt;
    int                 i;
    int                 j;
    dt = {40'd0, it.step_dt};
    case (kind_t'(it.kind))
      KIND_ADD: begin
        if (n_boxes >= NB) begin
          expected_results.push_back(mk(ST_FULL, 0, 0, 0, 1'b1));
        end else begin
          tbl_x[n_boxes]   = it.pos_x;
          tbl_y[n_boxes]   = it.pos_y;
          tbl_w[n_boxes]   = {33'd0, it.box_width};
          tbl_h[n_boxes]   = {33'd0, it.box_height};
          tbl_fix[n_boxes] = it.fixed_flag;
          spd_x[n_boxes]   = 0;
          spd_y[n_boxes]   = 0;
          expected_results.push_back(mk(ST_OK, n_boxes, tbl_x[n_boxes],
                                        tbl_y[n_boxes], 1'b1));
          n_boxes++;
        end
      end
      KIND_VEL: begin
        if (it.body_index >= n_boxes) begin
          expected_results.push_back(mk(ST_BADIX, it.body_index, 0, 0, 1'b1));
        end else begin
          spd_x[it.body_index] = it.vel_x;
          spd_y[it.body_index] = it.vel_y;
          expected_results.push_back(mk(ST_OK, it.body_index, 0, 0, 1'b1));
        end
      end
      KIND_STEP: begin
        step_count++;
        if (n_boxes == 0) begin
          expected_results.push_back(mk(ST_EMPTY, 0, 0, 0, 1'b1));
        end else begin
          for (i = 0; i < n_boxes; i++) begin
            if (!tbl_fix[i]) begin
              tbl_x[i] = clamp32(tbl_x[i] + motion(spd_x[i], dt));
              tbl_y[i] = clamp32(tbl_y[i] + motion(spd_y[i], dt));
              spd_x[i] = 0;
              spd_y[i] = 0;
            end
          end
          for (i = 0; i < n_boxes; i++)
            for (j = i + 1; j < n_boxes; j++)
              separate_pair(i, j);
          for (i = 0; i < n_boxes; i++)
            expected_results.push_back(mk(ST_OK, i, tbl_x[i], tbl_y[i],
                                          i == n_boxes - 1));
        end
      end
      default: begin
        // drop: unused kind gives no result
      end
    endcase
  endtask

  // Compare one returned result with the oldest expectation
  task automatic compare_result(out_item_t got);
    out_item_t exp_r;
    result_count++;
    if (expected_results.size() == 0) begin
      $error("unexpected result %p", got);
      fail_count++;
      return;
    end
    exp_r = expected_results.pop_front();
    if (got.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      fail_count++;
    end
    if (got.out_index !== exp_r.out_index) begin
      $error("out_index: expected %0d, got %0d", exp_r.out_index, got.out_index);
      fail_count++;
    end
    if (got.out_x !== exp_r.out_x) begin
      $error("out_x: expected %0h, got %0h", exp_r.out_x, got.out_x);
      fail_count++;
    end
    if (got.out_y !== exp_r.out_y) begin
      $error("out_y: expected %0h, got %0h", exp_r.out_y, got.out_y);
      fail_count++;
    end
    if (got.last !== exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, got.last);
      fail_count++;
    end
  endtask

  initial begin
    fail_count   = 0;
    n_boxes      = 0;
    step_count   = 0;
    result_count = 0;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_world(in_data);
      if (out_valid && out_ready) compare_result(out_data);
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the box table block: directed corner items, then
// random worlds of boxes, velocities and steps with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import aws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        step_count;
  int        result_count;
  int        sent;

  aabb_world_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  aws_scoreboard i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .step_count   (step_count),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $signed($urandom_range(0, 16'hFFFF)) - 32'sd32768;
    endcase
  endfunction

  // Hand one item over at the falling edge and hold it until accepted
  task automatic send_item(in_item_t it);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    in_data  = '0;
    sent++;
  endtask

  function automatic in_item_t add_item(logic [31:0] x, logic [31:0] y,
                                        logic [30:0] w, logic [30:0] h, logic f);
    in_item_t it;
    it = '0;
    it.kind       = KIND_ADD;
    it.pos_x      = x;
    it.pos_y      = y;
    it.box_width  = w;
    it.box_height = h;
    it.fixed_flag = f;
    it.body_index = 4'($urandom());
    it.vel_x      = $urandom();
    it.step_dt    = 24'($urandom());
    return it;
  endfunction

  function automatic in_item_t vel_item(logic [3:0] idx, logic [31:0] vx,
                                        logic [31:0] vy);
    in_item_t it;
    it = '0;
    it.kind       = KIND_VEL;
    it.body_index = idx;
    it.vel_x      = vx;
    it.vel_y      = vy;
    it.pos_x      = $urandom();
    it.box_width  = 31'($urandom());
    return it;
  endfunction

  function automatic in_item_t step_item(logic [23:0] dt);
    in_item_t it;
    it = '0;
    it.kind       = KIND_STEP;
    it.step_dt    = dt;
    it.pos_y      = $urandom();
    it.box_height = 31'($urandom());
    it.vel_y      = $urandom();
    it.fixed_flag = 1'($urandom());
    return it;
  endfunction

  // Random stalls on the result side, with quiet stretches
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ready = 1'b1;
        repeat ($urandom_range(20, 200)) @(negedge clk);
      end
      out_ready = 1'b0;
      repeat (gap_len()) @(negedge clk);
      out_ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Timeout: steps on full 16-box tables plus stalls, many times over
  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_item_t it;
    int       i;
    int       k;
    sent        = 0;
    in_valid    = 1'b0;
    in_data     = '0;
    rst_n       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty step, bad index, extremes, overlap, full table
    send_item(step_item(24'hFFFFFF));
    send_item(vel_item(4'd0, 32'd5, 32'd5));
    send_item(vel_item(4'd15, 32'h7FFF_FFFF, 32'h8000_0000));
    it = '1;
    it.kind = KIND_NONE;
    send_item(it);
    send_item(add_item(32'h7FFF_FF00, 32'h8000_0000, 31'h7FFF_FFFF,
                       31'd0, 1'b0));
    send_item(add_item(32'h8000_0000, 32'h7FFF_FFFF, 31'd0,
                       31'h7FFF_FFFF, 1'b1));
    send_item(add_item(32'd0, 32'd0, 31'd2560, 31'd2560, 1'b0));
    send_item(add_item(32'd1280, 32'd256, 31'd2560, 31'd2560, 1'b0));
    send_item(add_item(32'd2560, 32'd0, 31'd256, 31'd256, 1'b1));
    send_item(vel_item(4'd0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(vel_item(4'd1, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(vel_item(4'd2, 32'h1234, 32'hFFFF_0000));
    send_item(step_item(24'hFFFFFF));
    send_item(vel_item(4'd3, 32'hFFFF_FF80, 32'd128));
    send_item(step_item(24'd0));
    for (i = 5; i < 17; i++)
      send_item(add_item(i * 32'd512, 32'd300, 31'd600, 31'd600, i[0]));
    send_item(step_item(24'd1));
    send_item(vel_item(4'd15, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(step_item(24'h008000));
    wait (pending == 0);

    // Random worlds: no reset follows the directed part, whose table is full,
    // so these items exercise velocity and step with full tables
    while (sent < 200) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        send_item(add_item(rand_word(), rand_word(),
                           31'($urandom_range(0, 3) == 0 ? $urandom() :
                               $urandom_range(0, 4096)),
                           31'($urandom_range(0, 3) == 0 ? $urandom() :
                               $urandom_range(0, 4096)),
                           1'($urandom())));
      end else if (k < 65) begin
        send_item(vel_item(4'($urandom()), rand_word(), rand_word()));
      end else if (k < 95) begin
        send_item(step_item(24'($urandom_range(0, 3) == 0 ? $urandom() :
                                $urandom_range(0, 24'h02_0000))));
      end else begin
        it = '0;
        it.kind = KIND_NONE;
        it.pos_x = $urandom();
        it.vel_y = $urandom();
        send_item(it);
      end
    end

    // Drain and let the block settle
    wait (pending == 0);
    repeat (800) @(posedge clk);
    $display("Ran %0d items with %0d steps; %0d results checked.",
             sent, step_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
